[sv/dct_pkg.sv]
`default_nettype none
package dct_pkg;

  // Base codes held in the window
  localparam logic [2:0] BASE_A       = 3'd0;
  localparam logic [2:0] BASE_C       = 3'd1;
  localparam logic [2:0] BASE_G       = 3'd2;
  localparam logic [2:0] BASE_T       = 3'd3;
  localparam logic [2:0] CODE_UNKNOWN = 3'd4;
  localparam logic [2:0] CODE_DROP    = 3'd7;

  localparam logic [7:0] AA_UNKNOWN = "X";
  localparam logic [7:0] AA_STOP    = "*";

  localparam logic [2:0] FRAME_MASK_RESET = 3'd7;
  localparam logic [2:0] SEEN_MAX         = 3'd4;
  localparam logic [1:0] PHASE_LAST       = 2'd2;

  // Standard genetic code, indexed by {first, second, third} base
  localparam logic [7:0] AA_TABLE [0:63] = '{
    "K","N","K","N","T","T","T","T","R","S","R","S","I","I","M","I",
    "Q","H","Q","H","P","P","P","P","R","R","R","R","L","L","L","L",
    "E","D","E","D","A","A","A","A","G","G","G","G","V","V","V","V",
    "*","Y","*","Y","S","S","S","S","*","C","W","C","L","F","L","F"
  };

  // One sequence character request
  typedef struct packed {
    logic [7:0] symbol;
    logic       sequence_start;
  } dct_item_t;

  // Result of handling one character
  typedef struct packed {
    logic       emit;
    logic [7:0] amino_acid;
    logic [1:0] frame;
    logic       is_stop;
  } dct_result_t;

  // Fold case, map U to T, sort into base, unknown or drop
  function automatic logic [2:0] classify(input logic [7:0] sym);
    logic [7:0] c;
    c = sym;
    if (c >= "a" && c <= "z") begin
      c = c - 8'd32;
    end
    case (c)
      "A":      classify = BASE_A;
      "C":      classify = BASE_C;
      "G":      classify = BASE_G;
      "T", "U": classify = BASE_T;
      "N", "X", ".", "-": classify = CODE_UNKNOWN;
      default:  classify = CODE_DROP;
    endcase
  endfunction

endpackage
`default_nettype wire

[sv/dct_in_stage.sv]
`default_nettype none
module dct_in_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        symbol,
  input  wire logic              sequence_start,
  input  wire logic              advance,
  output logic                   held,
  output dct_pkg::dct_item_t     item
);
  import dct_pkg::*;

  // Take a new request when empty or when the held one moves on
  assign in_ready = !held || advance;

  // Hold the request until the codon unit consumes it
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (advance) begin
      held <= 1'b0;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.symbol         <= symbol;
      item.sequence_start <= sequence_start;
    end
  end

endmodule
`default_nettype wire

[sv/dct_codon_unit.sv]
`default_nettype none
module dct_codon_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               advance,
  input  wire dct_pkg::dct_item_t item,
  input  wire logic [2:0]         frame_mask,
  output dct_pkg::dct_result_t    result
);
  import dct_pkg::*;

  logic [2:0] window0;
  logic [2:0] window1;
  logic [1:0] phase;
  logic [2:0] bases_seen;

  logic [2:0] window0_next;
  logic [2:0] window1_next;
  logic [1:0] phase_next;
  logic [2:0] bases_seen_next;

  logic [2:0] w0_cur;
  logic [2:0] w1_cur;
  logic [1:0] phase_cur;
  logic [2:0] seen_cur;
  logic [2:0] code;
  logic       drop;
  logic       complete;
  logic [1:0] frame_id;
  logic [5:0] idx;
  logic [7:0] aa;
  logic       unknown;

  // Apply sequence start before the character is handled
  always_comb begin
    w0_cur    = item.sequence_start ? 3'd0 : window0;
    w1_cur    = item.sequence_start ? 3'd0 : window1;
    phase_cur = item.sequence_start ? 2'd0 : phase;
    seen_cur  = item.sequence_start ? 3'd0 : bases_seen;
  end

  // Classify the character and look up the codon it completes
  always_comb begin
    code     = classify(item.symbol);
    drop     = (code == CODE_DROP);
    complete = (seen_cur >= 3'd2);
    frame_id = (phase_cur >= PHASE_LAST) ? 2'd0 : phase_cur + 2'd1;
    unknown  = w0_cur[2] || w1_cur[2] || code[2];
    idx      = {w0_cur[1:0], w1_cur[1:0], code[1:0]};
    aa       = AA_TABLE[idx];

    result.emit       = !drop && complete && frame_mask[frame_id];
    result.frame      = frame_id;
    result.amino_acid = unknown ? AA_UNKNOWN : aa;
    result.is_stop    = !unknown && (aa == AA_STOP);
  end

  // Shift the window and step the position on a base
  always_comb begin
    window0_next    = w0_cur;
    window1_next    = w1_cur;
    phase_next      = phase_cur;
    bases_seen_next = seen_cur;
    if (!drop) begin
      window0_next    = w1_cur;
      window1_next    = code;
      phase_next      = (phase_cur >= PHASE_LAST) ? 2'd0 : phase_cur + 2'd1;
      bases_seen_next = (seen_cur < SEEN_MAX) ? seen_cur + 3'd1 : seen_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window0    <= 3'd0;
      window1    <= 3'd0;
      phase      <= 2'd0;
      bases_seen <= 3'd0;
    end else if (advance) begin
      window0    <= window0_next;
      window1    <= window1_next;
      phase      <= phase_next;
      bases_seen <= bases_seen_next;
    end
  end

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase != 2'd3)
    else $error("phase left its range");

  a_seen_sat: assert property (@(posedge clk) disable iff (rst)
    bases_seen <= SEEN_MAX)
    else $error("bases_seen passed saturation");

  a_drop_holds: assert property (@(posedge clk) disable iff (rst)
    advance && drop && !item.sequence_start
      |=> $stable(phase) && $stable(bases_seen) && $stable(window1))
    else $error("dropped character changed state");

endmodule
`default_nettype wire

[sv/dna_codon_translator.sv]
`default_nettype none
// Forward-frame codon translator, standard genetic code. Feed one ASCII
// sequence character per request; letters are case-folded, U reads as T,
// N/X/./- count as an unknown base and every other byte is dropped without
// moving the position. Each base that completes a codon in an enabled
// frame (frame_mask bit f, written through the cfg port, reset 7) yields
// one result: amino acid letter, frame 0..2 and a stop flag; codons with an
// unknown base give 'X'. The first two bases of a sequence give nothing.
// Throughput is one character per cycle while the output is not stalled;
// a request passes through the input register and the result register.
// Write configuration only while no requests are in flight.
module dna_codon_translator (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [2:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] symbol,
  input  wire logic       sequence_start,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      amino_acid,
  output logic [1:0]      frame,
  output logic            is_stop
);
  import dct_pkg::*;

  logic        held;
  logic        advance;
  logic [2:0]  frame_mask;
  dct_item_t   item;
  dct_result_t result;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_mask <= FRAME_MASK_RESET;
    end else if (cfg_valid) begin
      frame_mask <= cfg_data;
    end
  end

  // Move the held request on when the result slot is free
  assign advance = held && (!out_valid || out_ready);

  dct_in_stage u_in_stage (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .symbol         (symbol),
    .sequence_start (sequence_start),
    .advance        (advance),
    .held           (held),
    .item           (item)
  );

  dct_codon_unit u_codon_unit (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .item       (item),
    .frame_mask (frame_mask),
    .result     (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && result.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.emit) begin
      amino_acid <= result.amino_acid;
      frame      <= result.frame;
      is_stop    <= result.is_stop;
    end
  end

  a_stop_letter: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_stop == (amino_acid == AA_STOP)))
    else $error("stop flag disagrees with letter");

  a_frame_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> frame != 2'd3)
    else $error("frame out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !advance)
    else $error("pending result overwritten");

endmodule
`default_nettype wire
